/* hdl/touch_report_decoder_macros.svh */
// Assertion macros shared by the touch report decoder RTL.
`ifndef TOUCH_REPORT_DECODER_MACROS_SVH
`define TOUCH_REPORT_DECODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/trd_pkg.sv */
// Types, constants and helpers for the touch report decoder.
package trd_pkg;

	localparam int MAX_SLOTS_DEF = 10;

	localparam int SLOT_W   = 4;
	localparam int BYTE_W   = 8;
	localparam int RAW_W    = 12;
	localparam int NUM_W    = 16;
	localparam int DEN_W    = 13;
	localparam int PROD_W   = RAW_W + NUM_W;
	localparam int REM_W    = DEN_W + 1;
	localparam int POS_W    = 16;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_W   = 5;

	typedef logic [1:0] event_kind_t;

	localparam event_kind_t EV_PRESS      = 2'd0;
	localparam event_kind_t EV_RELEASE    = 2'd1;
	localparam event_kind_t EV_BUTTONS_UP = 2'd2;
	localparam event_kind_t EV_SYNC       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_PROTOCOL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HEIGHT   = 3'd5;

	localparam logic [NUM_W-1:0] PANEL_WIDTH_RST   = 16'd720;
	localparam logic [NUM_W-1:0] PANEL_HEIGHT_RST  = 16'd1440;
	localparam logic [DEN_W-1:0] SENSOR_WIDTH_RST  = 13'd2048;
	localparam logic [DEN_W-1:0] SENSOR_HEIGHT_RST = 13'd2048;

	localparam logic [BYTE_W-1:0] BYTE_EMPTY = 8'hFF;
	localparam logic [BYTE_W-1:0] PRESSURE_DEFAULT = 8'd1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

	function automatic logic [POS_W-1:0] sat_pos(input logic [PROD_W-1:0] q);
		logic over;
		over = |q[PROD_W-1:POS_W];
		return over ? {POS_W{1'b1}} : q[POS_W-1:0];
	endfunction

endpackage

/* hdl/touch_report_decoder.sv */
// Touch report decoder: slot records in, press/release/button-up/sync events out.
// A touched slot passes through the shared multiply/divide unit twice, for x and then for y,
// each pass a multiply step and then the restoring divide steps; other records skip the arithmetic.
// One record is in flight: the next is taken only once the last record is done. An emitting
// frame end walks all MAX_SLOTS slots in slot protocol, emitting releases, then any anonymous
// release, button-up and sync beats; any output stall holds it. Reset clears state; registers take defaults.
`include "touch_report_decoder_macros.svh"

module touch_report_decoder #(
	parameter int MAX_SLOTS = trd_pkg::MAX_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [trd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [trd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [trd_pkg::SLOT_W-1:0]        slot,
	input  logic [trd_pkg::BYTE_W-1:0]        high_nibbles,
	input  logic [trd_pkg::BYTE_W-1:0]        x_low,
	input  logic [trd_pkg::BYTE_W-1:0]        y_low,
	input  logic [trd_pkg::BYTE_W-1:0]        pressure_byte,
	input  logic                              frame_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output trd_pkg::event_kind_t              event_kind,
	output logic [trd_pkg::SLOT_W-1:0]        event_slot,
	output logic [trd_pkg::POS_W-1:0]         pos_x,
	output logic [trd_pkg::POS_W-1:0]         pos_y,
	output logic [trd_pkg::BYTE_W-1:0]        pressure,
	output logic [trd_pkg::COUNT_W-1:0]       finger_count,
	output logic                              last
);
	import trd_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_MUL   = 4'd1;
	localparam logic [ST_W-1:0] ST_DIV   = 4'd2;
	localparam logic [ST_W-1:0] ST_PRESS = 4'd3;
	localparam logic [ST_W-1:0] ST_END   = 4'd4;
	localparam logic [ST_W-1:0] ST_REL   = 4'd5;
	localparam logic [ST_W-1:0] ST_ANON  = 4'd6;
	localparam logic [ST_W-1:0] ST_BUP   = 4'd7;
	localparam logic [ST_W-1:0] ST_SYNC  = 4'd8;

	// configuration
	logic                 slot_protocol_q;
	logic                 pressure_enable_q;
	logic [NUM_W-1:0]     panel_width_q;
	logic [NUM_W-1:0]     panel_height_q;
	logic [DEN_W-1:0]     sensor_width_q;
	logic [DEN_W-1:0]     sensor_height_q;

	// control state
	logic [ST_W-1:0]      state_q;
	logic [MAX_SLOTS-1:0] down_now_q;
	logic [MAX_SLOTS-1:0] down_before_q;
	logic [MAX_SLOTS-1:0] gone_q;
	logic [COUNT_W-1:0]   frame_fingers_q;
	logic [COUNT_W-1:0]   previous_fingers_q;
	logic [STEP_W-1:0]    step_q;
	logic                 sel_y_q;
	logic                 out_valid_q;

	// record and arithmetic payload
	logic [SLOT_W-1:0]    slot_q;
	logic [RAW_W-1:0]     raw_x_q;
	logic [RAW_W-1:0]     raw_y_q;
	logic [BYTE_W-1:0]    pb_q;
	logic                 end_q;
	logic [PROD_W-1:0]    dq_q;
	logic [REM_W-1:0]     rem_q;
	logic [POS_W-1:0]     px_q;
	logic [POS_W-1:0]     py_q;

	// output register
	event_kind_t          kind_q;
	logic [SLOT_W-1:0]    ev_slot_q;
	logic [POS_W-1:0]     ev_x_q;
	logic [POS_W-1:0]     ev_y_q;
	logic [BYTE_W-1:0]    ev_pr_q;
	logic [COUNT_W-1:0]   ev_count_q;
	logic                 ev_last_q;

	logic                 in_fire;
	logic                 in_range;
	logic                 is_empty;
	logic [MAX_SLOTS-1:0] slot_bit;
	logic                 out_free;
	logic                 emit_go;
	event_kind_t          emit_kind;
	logic [SLOT_W-1:0]    emit_slot;
	logic                 emit_last;
	logic                 emit_pos;
	logic [RAW_W-1:0]     mul_a;
	logic [NUM_W-1:0]     mul_b;
	logic [DEN_W-1:0]     den;
	logic [REM_W-1:0]     rem_sh;
	logic                 q_bit;
	logic [REM_W-1:0]     rem_next;
	logic [PROD_W-1:0]    quot;
	logic                 walk_done;
	logic                 frame_emit;
	logic                 beat_press;
	logic                 beat_end_kind;
	logic                 beat_data;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign in_range  = ({1'b0, slot} < (SLOT_W+1)'(MAX_SLOTS));
	assign is_empty  = (high_nibbles == BYTE_EMPTY) && (x_low == BYTE_EMPTY)
		&& (y_low == BYTE_EMPTY);
	assign out_free  = !out_valid_q || out_ready;
	assign walk_done = (step_q == STEP_W'(MAX_SLOTS - 1));
	assign frame_emit = (frame_fingers_q != '0) || (previous_fingers_q != '0);

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_bit[i] = (slot == SLOT_W'(i));
		end
	end

	// shared multiply and restoring divide step
	assign mul_a    = sel_y_q ? raw_y_q : raw_x_q;
	assign mul_b    = sel_y_q ? panel_height_q : panel_width_q;
	assign den      = sel_y_q ? sensor_height_q : sensor_width_q;
	assign rem_sh   = {rem_q[REM_W-2:0], dq_q[PROD_W-1]};
	assign q_bit    = (rem_sh >= {1'b0, den});
	assign rem_next = q_bit ? (rem_sh - {1'b0, den}) : rem_sh;
	assign quot     = {dq_q[PROD_W-2:0], q_bit};

	// event selection
	always_comb begin
		emit_go   = 1'b0;
		emit_kind = EV_SYNC;
		emit_slot = '0;
		emit_last = 1'b0;
		emit_pos  = 1'b0;
		unique case (state_q)
			ST_PRESS: begin
				emit_go   = out_free;
				emit_kind = EV_PRESS;
				emit_slot = slot_q;
				emit_last = !end_q;
				emit_pos  = 1'b1;
			end
			ST_REL: begin
				emit_go   = out_free && gone_q[0];
				emit_kind = EV_RELEASE;
				emit_slot = step_q[SLOT_W-1:0];
			end
			ST_ANON: begin
				emit_go   = out_free;
				emit_kind = EV_RELEASE;
			end
			ST_BUP: begin
				emit_go   = out_free;
				emit_kind = EV_BUTTONS_UP;
			end
			ST_SYNC: begin
				emit_go   = out_free;
				emit_kind = EV_SYNC;
				emit_last = 1'b1;
			end
			default: begin
				emit_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_protocol_q   <= 1'b1;
			pressure_enable_q <= 1'b0;
			panel_width_q     <= PANEL_WIDTH_RST;
			panel_height_q    <= PANEL_HEIGHT_RST;
			sensor_width_q    <= SENSOR_WIDTH_RST;
			sensor_height_q   <= SENSOR_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLOT_PROTOCOL:   slot_protocol_q   <= cfg_data[0];
				CFG_PRESSURE_ENABLE: pressure_enable_q <= cfg_data[0];
				CFG_PANEL_WIDTH:     panel_width_q     <= cfg_data;
				CFG_PANEL_HEIGHT:    panel_height_q    <= cfg_data;
				CFG_SENSOR_WIDTH:    sensor_width_q    <= cfg_data[DEN_W-1:0];
				CFG_SENSOR_HEIGHT:   sensor_height_q   <= cfg_data[DEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			down_now_q         <= '0;
			down_before_q      <= '0;
			gone_q             <= '0;
			frame_fingers_q    <= '0;
			previous_fingers_q <= '0;
			step_q             <= '0;
			sel_y_q            <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						sel_y_q <= 1'b0;
						if (in_range && !is_empty) begin
							if (frame_fingers_q != COUNT_MAX) begin
								frame_fingers_q <= frame_fingers_q + 1'b1;
							end
							if (slot_protocol_q) begin
								down_now_q <= down_now_q | slot_bit;
							end
							state_q <= ST_MUL;
						end else begin
							if (in_range && slot_protocol_q) begin
								down_now_q <= down_now_q & ~slot_bit;
							end
							state_q <= ST_END;
						end
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(PROD_W - 1)) begin
						if (sel_y_q) begin
							state_q <= ST_PRESS;
						end else begin
							sel_y_q <= 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_PRESS: begin
					if (emit_go) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					if (!end_q) begin
						state_q <= ST_IDLE;
					end else if (!frame_emit) begin
						previous_fingers_q <= frame_fingers_q;
						frame_fingers_q    <= '0;
						state_q            <= ST_IDLE;
					end else if (slot_protocol_q) begin
						gone_q        <= down_before_q & ~down_now_q;
						down_before_q <= down_now_q;
						step_q        <= '0;
						state_q       <= ST_REL;
					end else if (frame_fingers_q == '0) begin
						state_q <= ST_ANON;
					end else begin
						state_q <= ST_SYNC;
					end
				end
				ST_REL: begin
					if (!gone_q[0] || emit_go) begin
						gone_q <= gone_q >> 1;
						step_q <= step_q + 1'b1;
						if (walk_done) begin
							state_q <= (frame_fingers_q == '0) ? ST_BUP : ST_SYNC;
						end
					end
				end
				ST_ANON: begin
					if (emit_go) begin
						state_q <= ST_SYNC;
					end
				end
				ST_BUP: begin
					if (emit_go) begin
						state_q <= ST_SYNC;
					end
				end
				ST_SYNC: begin
					if (emit_go) begin
						previous_fingers_q <= frame_fingers_q;
						frame_fingers_q    <= '0;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// record capture and divider datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q  <= slot;
			raw_x_q <= {high_nibbles[7:4], x_low};
			raw_y_q <= {high_nibbles[3:0], y_low};
			pb_q    <= pressure_byte;
			end_q   <= frame_end;
		end
		if (state_q == ST_MUL) begin
			dq_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dq_q  <= quot;
			rem_q <= rem_next;
			if (step_q == STEP_W'(PROD_W - 1)) begin
				if (sel_y_q) begin
					py_q <= sat_pos(quot);
				end else begin
					px_q <= sat_pos(quot);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			kind_q     <= emit_kind;
			ev_slot_q  <= emit_slot;
			ev_x_q     <= emit_pos ? px_q : '0;
			ev_y_q     <= emit_pos ? py_q : '0;
			ev_pr_q    <= emit_pos ? (pressure_enable_q ? pb_q : PRESSURE_DEFAULT) : '0;
			ev_count_q <= frame_fingers_q;
			ev_last_q  <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign event_slot   = ev_slot_q;
	assign pos_x        = ev_x_q;
	assign pos_y        = ev_y_q;
	assign pressure     = ev_pr_q;
	assign finger_count = ev_count_q;
	assign last         = ev_last_q;

	assign beat_press    = out_valid_q && (kind_q == EV_PRESS);
	assign beat_end_kind = (kind_q == EV_PRESS) || (kind_q == EV_SYNC);
	assign beat_data     = |{ev_x_q, ev_y_q, ev_pr_q};

	`TRD_ASSERT_IMP(a_last_kind, out_valid && last, beat_end_kind, "last beat not press or sync")
	`TRD_ASSERT_IMP(a_press_count, beat_press, finger_count != '0, "press beat with no fingers")
	`TRD_ASSERT_IMP(a_idle_fields, out_valid && !beat_press, !beat_data, "stray press fields")
	`TRD_ASSERT_NXT(a_one_record, in_valid && in_ready, !in_ready, "record taken while busy")

endmodule

/* tb/touch_report_decoder_tb.sv */
// Self-checking testbench for the touch report decoder: slot records in, touch events out.
module touch_report_decoder_tb;
	import trd_pkg::*;

	localparam int IDLE_PCT     = 27;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES  = 600;
	localparam int PHASE_ITEMS  = 75;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct {
		event_kind_t           event_kind;
		logic [SLOT_W-1:0]     event_slot;
		logic [POS_W-1:0]      pos_x;
		logic [POS_W-1:0]      pos_y;
		logic [BYTE_W-1:0]     pressure;
		logic [COUNT_W-1:0]    finger_count;
		logic                  last;
	} touch_event_t;

	class touch_event_board;
		bit                      slot_protocol;
		bit                      pressure_enable;
		bit [NUM_W-1:0]          panel_w;
		bit [NUM_W-1:0]          panel_h;
		bit [DEN_W-1:0]          sensor_w;
		bit [DEN_W-1:0]          sensor_h;
		bit [MAX_SLOTS_DEF-1:0]  down_now;
		bit [MAX_SLOTS_DEF-1:0]  down_prev;
		bit [COUNT_W-1:0]        fingers;
		bit [COUNT_W-1:0]        prev_fingers;
		touch_event_t            due[$];
		touch_event_t            held;
		bit                      have_held;
		int                      errors;

		function new();
			slot_protocol   = 1'b1;
			pressure_enable = 1'b0;
			panel_w         = PANEL_WIDTH_RST;
			panel_h         = PANEL_HEIGHT_RST;
			sensor_w        = SENSOR_WIDTH_RST;
			sensor_h        = SENSOR_HEIGHT_RST;
			down_now        = '0;
			down_prev       = '0;
			fingers         = '0;
			prev_fingers    = '0;
			have_held       = 1'b0;
			errors          = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SLOT_PROTOCOL:   slot_protocol = val[0];
				CFG_PRESSURE_ENABLE: pressure_enable = val[0];
				CFG_PANEL_WIDTH:     panel_w = val;
				CFG_PANEL_HEIGHT:    panel_h = val;
				CFG_SENSOR_WIDTH:    sensor_w = val[DEN_W-1:0];
				CFG_SENSOR_HEIGHT:   sensor_h = val[DEN_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [POS_W-1:0] scaled(bit [RAW_W-1:0] raw, bit [NUM_W-1:0] num,
				bit [DEN_W-1:0] den);
			longint unsigned q;
			if (den == 0)
				return '1;
			q = (longint'(raw) * longint'(num)) / longint'(den);
			return (q > 65535) ? '1 : q[POS_W-1:0];
		endfunction

		function void emit(event_kind_t kind, bit [SLOT_W-1:0] s, bit [POS_W-1:0] px,
				bit [POS_W-1:0] py, bit [BYTE_W-1:0] pr);
			touch_event_t ev;
			ev.event_kind   = kind;
			ev.event_slot   = s;
			ev.pos_x        = px;
			ev.pos_y        = py;
			ev.pressure     = pr;
			ev.finger_count = fingers;
			ev.last         = 1'b0;
			if (have_held)
				due.push_back(held);
			held      = ev;
			have_held = 1'b1;
		endfunction

		function void note_record(bit [SLOT_W-1:0] s, bit [BYTE_W-1:0] hn, bit [BYTE_W-1:0] xl,
				bit [BYTE_W-1:0] yl, bit [BYTE_W-1:0] pb, bit fe);
			bit [RAW_W-1:0]         rx;
			bit [RAW_W-1:0]         ry;
			bit [MAX_SLOTS_DEF-1:0] gone;
			if (s < MAX_SLOTS_DEF) begin
				if (hn == BYTE_EMPTY && xl == BYTE_EMPTY && yl == BYTE_EMPTY) begin
					if (slot_protocol)
						down_now[s] = 1'b0;
				end else begin
					rx = {hn[7:4], xl};
					ry = {hn[3:0], yl};
					if (fingers != COUNT_MAX)
						fingers++;
					if (slot_protocol)
						down_now[s] = 1'b1;
					emit(EV_PRESS, s, scaled(rx, panel_w, sensor_w), scaled(ry, panel_h, sensor_h),
						pressure_enable ? pb : PRESSURE_DEFAULT);
				end
			end
			if (fe) begin
				if (fingers != 0 || prev_fingers != 0) begin
					if (slot_protocol) begin
						gone = down_prev & ~down_now;
						for (int i = 0; i < MAX_SLOTS_DEF; i++)
							if (gone[i])
								emit(EV_RELEASE, SLOT_W'(i), '0, '0, '0);
						if (fingers == 0)
							emit(EV_BUTTONS_UP, '0, '0, '0, '0);
						down_prev = down_now;
					end else if (fingers == 0) begin
						emit(EV_RELEASE, '0, '0, '0, '0);
					end
					emit(EV_SYNC, '0, '0, '0, '0);
				end
				prev_fingers = fingers;
				fingers      = '0;
			end
			if (have_held) begin
				held.last = 1'b1;
				due.push_back(held);
				have_held = 1'b0;
			end
		endfunction

		function void report(string field, longint want, longint got);
			if (errors < 40)
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_event(touch_event_t got);
			touch_event_t want;
			if (due.size() == 0) begin
				if (errors < 40)
					$display("%0t: event beat expected none, got kind %0d slot %0d",
						$time, got.event_kind, got.event_slot);
				errors++;
				return;
			end
			want = due.pop_front();
			if (got.event_kind !== want.event_kind)
				report("event_kind", longint'(want.event_kind), longint'(got.event_kind));
			if (got.event_slot !== want.event_slot)
				report("event_slot", longint'(want.event_slot), longint'(got.event_slot));
			if (got.pos_x !== want.pos_x)
				report("pos_x", longint'(want.pos_x), longint'(got.pos_x));
			if (got.pos_y !== want.pos_y)
				report("pos_y", longint'(want.pos_y), longint'(got.pos_y));
			if (got.pressure !== want.pressure)
				report("pressure", longint'(want.pressure), longint'(got.pressure));
			if (got.finger_count !== want.finger_count)
				report("finger_count", longint'(want.finger_count),
					longint'(got.finger_count));
			if (got.last !== want.last)
				report("last", longint'(want.last), longint'(got.last));
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [SLOT_W-1:0]      slot;
	logic [BYTE_W-1:0]      high_nibbles;
	logic [BYTE_W-1:0]      x_low;
	logic [BYTE_W-1:0]      y_low;
	logic [BYTE_W-1:0]      pressure_byte;
	logic                   frame_end;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	event_kind_t            event_kind;
	logic [SLOT_W-1:0]      event_slot;
	logic [POS_W-1:0]       pos_x;
	logic [POS_W-1:0]       pos_y;
	logic [BYTE_W-1:0]      pressure;
	logic [COUNT_W-1:0]     finger_count;
	logic                   last;

	touch_event_board board = new();
	bit no_idle   = 1'b0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;

	touch_report_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.slot         (slot),
		.high_nibbles (high_nibbles),
		.x_low        (x_low),
		.y_low        (y_low),
		.pressure_byte(pressure_byte),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.event_slot   (event_slot),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pressure     (pressure),
		.finger_count (finger_count),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Event sink: check each beat, stall at random, hold off for a long stretch on request.
	always @(posedge clk) begin
		touch_event_t got;
		if (arst_n && out_valid && out_ready) begin
			got.event_kind   = event_kind;
			got.event_slot   = event_slot;
			got.pos_x        = pos_x;
			got.pos_y        = pos_y;
			got.pressure     = pressure;
			got.finger_count = finger_count;
			got.last         = last;
			board.check_event(got);
		end
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic apply_settings(input bit proto, input bit pren, input logic [15:0] pw,
			input logic [15:0] ph, input logic [15:0] sw, input logic [15:0] sh);
		write_reg(CFG_SLOT_PROTOCOL, {15'd0, proto});
		write_reg(CFG_PRESSURE_ENABLE, {15'd0, pren});
		write_reg(CFG_PANEL_WIDTH, pw);
		write_reg(CFG_PANEL_HEIGHT, ph);
		write_reg(CFG_SENSOR_WIDTH, sw);
		write_reg(CFG_SENSOR_HEIGHT, sh);
		cfg_we <= 1'b0;
	endtask

	task automatic send_record(input logic [SLOT_W-1:0] s, input logic [7:0] hn,
			input logic [7:0] xl, input logic [7:0] yl, input logic [7:0] pb, input logic fe);
		int gap;
		in_valid      <= 1'b1;
		slot          <= s;
		high_nibbles  <= hn;
		x_low         <= xl;
		y_low         <= yl;
		pressure_byte <= pb;
		frame_end     <= fe;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_record(s, hn, xl, yl, pb, fe);
		gap = 0;
		if (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait for every due event, then idle long enough for the datapath to settle.
	task automatic drain();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] coord_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_panel();
		case ($urandom_range(0, 3))
			0:       return 16'd1;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_sensor();
		case ($urandom_range(0, 5))
			0:       return 16'd1;
			1:       return 16'd4096;
			2:       return 16'($urandom_range(4097, 8191));
			default: return 16'($urandom_range(1, 4096));
		endcase
	endfunction

	// One frame of slot records: mostly well formed, some empty, long or broken.
	task automatic send_frame(inout int counted);
		int  style;
		int  len;
		bit  blank;
		bit  fe;
		logic [SLOT_W-1:0] s;
		style = $urandom_range(0, 99);
		if (style < 55)
			len = $urandom_range(1, 10);
		else if (style < 75)
			len = $urandom_range(1, 3);
		else if (style < 85)
			len = $urandom_range(16, 20);
		else
			len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			if (style >= 75 && style < 85)
				s = SLOT_W'($urandom_range(0, MAX_SLOTS_DEF - 1));
			else if ($urandom_range(0, 99) < 88)
				s = SLOT_W'($urandom_range(0, MAX_SLOTS_DEF - 1));
			else
				s = SLOT_W'($urandom_range(MAX_SLOTS_DEF, 15));
			if (style >= 55 && style < 75)
				blank = 1'b1;
			else if (style >= 75 && style < 85)
				blank = 1'b0;
			else
				blank = ($urandom_range(0, 99) < 25);
			fe = (style >= 85) ? ($urandom_range(0, 2) == 0) : (i == len - 1);
			if (blank)
				send_record(s, BYTE_EMPTY, BYTE_EMPTY, BYTE_EMPTY, 8'($urandom_range(0, 255)),
					fe);
			else
				send_record(s, coord_byte(), coord_byte(), coord_byte(),
					8'($urandom_range(0, 255)), fe);
			counted++;
		end
	endtask

	initial begin
		int sent;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		slot          = '0;
		high_nibbles  = '0;
		x_low         = '0;
		y_low         = '0;
		pressure_byte = '0;
		frame_end     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(1'b1, 1'b1, 16'd720, 16'd1440, 16'd2048, 16'd2048);
		// origin, x and y at full scale, frame end with fingers down
		send_record(4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_record(4'd9, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 1'b0);
		send_record(4'd5, 8'hFF, 8'hFE, 8'hFF, 8'h80, 1'b0);
		send_record(4'd3, 8'h0F, 8'hFF, 8'h00, 8'h7F, 1'b1);
		// empty slot and out-of-range slot inside a frame; untouched slots stay down
		send_record(4'd0, BYTE_EMPTY, BYTE_EMPTY, BYTE_EMPTY, 8'h00, 1'b0);
		send_record(4'd12, 8'h12, 8'h34, 8'h56, 8'h9A, 1'b0);
		send_record(4'd9, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1);
		// frame with no fingers after one with fingers, ended by an ignored slot
		send_record(4'd9, BYTE_EMPTY, BYTE_EMPTY, BYTE_EMPTY, 8'h00, 1'b0);
		send_record(4'd5, BYTE_EMPTY, BYTE_EMPTY, BYTE_EMPTY, 8'h00, 1'b0);
		send_record(4'd3, BYTE_EMPTY, BYTE_EMPTY, BYTE_EMPTY, 8'h00, 1'b0);
		send_record(4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		// no fingers after no fingers: silent; then a lone touch in slot 7
		send_record(4'd2, BYTE_EMPTY, BYTE_EMPTY, BYTE_EMPTY, 8'h55, 1'b1);
		send_record(4'd10, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);
		send_record(4'd7, 8'hF0, 8'h0F, 8'hF0, 8'h01, 1'b1);
		// two of three bytes at 0xFF still count as a touch; repeated slot
		send_record(4'd7, 8'h00, 8'hFF, 8'hFF, 8'hFE, 1'b0);
		send_record(4'd7, 8'hFF, 8'h00, 8'hFF, 8'hEF, 1'b0);
		send_record(4'd7, 8'hFF, 8'hFF, 8'h00, 8'h10, 1'b1);
		in_valid <= 1'b0;
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_settings(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
				1: apply_settings(1'b0, 1'b0, 16'd1, 16'd1, 16'd4096, 16'd4096);
				2: apply_settings(1'b1, 1'b0, pick_panel(), pick_panel(), 16'd0, 16'd0);
				3: apply_settings(1'b0, 1'b1, pick_panel(), pick_panel(), pick_sensor(),
					pick_sensor());
				default: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					pick_panel(), pick_panel(), pick_sensor(), pick_sensor());
			endcase
			no_idle = (phase == 2);
			if (phase == 2)
				hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS)
				send_frame(sent);
			in_valid <= 1'b0;
			no_idle = 1'b0;
			drain();
		end

		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

/* files.f */
+incdir+hdl
hdl/trd_pkg.sv
hdl/touch_report_decoder.sv
tb/touch_report_decoder_tb.sv
